// ===== hdl/brl_pkg.sv =====
package brl_pkg;

    // Coordinate widths, fixed by the pixel word format.
    localparam int X_BITS = 9;
    localparam int Y_BITS = 8;
    localparam int C_BITS = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
    // The error term needs a sign bit and one bit of headroom over a distance.
    localparam int ERR_BITS = C_BITS + 2;
    localparam int COLOR_BITS = 16;
    localparam int ADDR_BITS = 32;

    // Default row pitch: one row is 2**ROW_SHIFT bytes.
    localparam int ROW_SHIFT_DEF = 10;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_TICK  = 1'b1
    } req_kind_t;

    typedef struct packed {
        req_kind_t              req_type;
        logic [X_BITS-1:0]      x_start;
        logic [Y_BITS-1:0]      y_start;
        logic [X_BITS-1:0]      x_end;
        logic [Y_BITS-1:0]      y_end;
        logic [COLOR_BITS-1:0]  color;
    } request_t;

    typedef struct packed {
        logic [X_BITS-1:0]      pixel_x;
        logic [Y_BITS-1:0]      pixel_y;
        logic [COLOR_BITS-1:0]  pixel_color;
        logic [ADDR_BITS-1:0]   pixel_address;
        logic                   last_pixel;
    } result_t;

    // Line parameters worked out from a start word.
    typedef struct packed {
        logic                   steep;
        logic [C_BITS-1:0]      major_pos;
        logic [C_BITS-1:0]      major_end;
        logic [C_BITS-1:0]      minor_pos;
        logic                   minor_down;
        logic [C_BITS-1:0]      delta_major;
        logic [C_BITS-1:0]      delta_minor;
        logic [ERR_BITS-1:0]    err_init;
    } line_setup_t;

endpackage

// ===== hdl/bresenham_line_rasterizer_core.sv =====
// Bresenham line rasterizer.
// Input channel (in_valid, in_stall, in_word): a start word loads two
// endpoints and a color; a tick word asks for the next pixel of the line.
// Output channel (out_valid, out_stall, out_word): one word per tick while a
// line is being drawn, carrying x, y, color, byte address and a last flag.
// A tick while idle and every start word give no output word; a start word
// in the middle of a line abandons that line.
// Configuration channel (cfg_valid, cfg_ready, cfg_data) writes the buffer
// base address; it is always ready. The user must write it only while idle; the block itself does not enforce this.
// An accepted tick sits in the input register, and its pixel then enters
// the result register once the result slot is free or emptying.
// Throughput is one word per cycle while the receiver does not stall.
// Reset clears both registers' valid flags, puts the walker in idle and sets
// the base address to zero.
// When the receiver stalls, the result word holds, the tick behind it waits
// in the input register, and in_stall rises once that register is occupied.
module bresenham_line_rasterizer_core #(
    parameter int ROW_SHIFT = brl_pkg::ROW_SHIFT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  brl_pkg::request_t             in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output brl_pkg::result_t              out_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [brl_pkg::ADDR_BITS-1:0] cfg_data
);
    import brl_pkg::*;

    logic                 held_valid;
    request_t             held_word;
    line_setup_t          setup;
    logic                 take;
    logic [ADDR_BITS-1:0] base_reg;

    // Base address register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_reg <= cfg_data;
        end
    end

    brl_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .take       (take),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    brl_setup u_setup (
        .req   (held_word),
        .setup (setup)
    );

    brl_step #(
        .ROW_SHIFT (ROW_SHIFT)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_word  (held_word),
        .setup      (setup),
        .base       (base_reg),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

endmodule

// ===== hdl/brl_in_stage.sv =====
module brl_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  brl_pkg::request_t in_word,
    input  logic              take,
    output logic              held_valid,
    output brl_pkg::request_t held_word
);
    import brl_pkg::*;

    logic     held_valid_reg;
    request_t held_word_reg;

    // The held word waits only while the downstream side cannot take it.
    assign in_stall   = held_valid_reg && !take;
    assign held_valid = held_valid_reg;
    assign held_word  = held_word_reg;

    // Valid flag of the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            held_valid_reg <= in_valid;
        end
    end

    // Payload of the input register.
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            held_word_reg <= in_word;
        end
    end

endmodule

// ===== hdl/brl_setup.sv =====
module brl_setup (
    input  brl_pkg::request_t    req,
    output brl_pkg::line_setup_t setup
);
    import brl_pkg::*;

    logic [C_BITS-1:0] x0;
    logic [C_BITS-1:0] y0;
    logic [C_BITS-1:0] x1;
    logic [C_BITS-1:0] y1;
    logic [C_BITS-1:0] dx;
    logic [C_BITS-1:0] dy;
    logic              steep;
    logic [C_BITS-1:0] a0;
    logic [C_BITS-1:0] b0;
    logic [C_BITS-1:0] a1;
    logic [C_BITS-1:0] b1;
    logic [C_BITS-1:0] lo_a;
    logic [C_BITS-1:0] lo_b;
    logic [C_BITS-1:0] hi_a;
    logic [C_BITS-1:0] hi_b;
    logic [C_BITS-1:0] d_major;

    // Widen the endpoints to the common coordinate width.
    assign x0 = C_BITS'(req.x_start);
    assign y0 = C_BITS'(req.y_start);
    assign x1 = C_BITS'(req.x_end);
    assign y1 = C_BITS'(req.y_end);

    assign dx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    assign dy = (y1 > y0) ? (y1 - y0) : (y0 - y1);

    // A steep line walks along y, so the roles of the axes swap.
    assign steep = dy > dx;
    assign a0    = steep ? y0 : x0;
    assign b0    = steep ? x0 : y0;
    assign a1    = steep ? y1 : x1;
    assign b1    = steep ? x1 : y1;

    // Order the endpoints so that the major coordinate rises.
    always_comb
    begin
        if (a0 > a1)
        begin
            lo_a = a1;
            lo_b = b1;
            hi_a = a0;
            hi_b = b0;
        end
        else
        begin
            lo_a = a0;
            lo_b = b0;
            hi_a = a1;
            hi_b = b1;
        end
    end

    assign d_major = hi_a - lo_a;

    always_comb
    begin
        setup.steep       = steep;
        setup.major_pos   = lo_a;
        setup.major_end   = hi_a;
        setup.minor_pos   = lo_b;
        setup.minor_down  = !(lo_b < hi_b);
        setup.delta_major = d_major;
        setup.delta_minor = (hi_b > lo_b) ? (hi_b - lo_b) : (lo_b - hi_b);
        setup.err_init    = -ERR_BITS'(d_major >> 1);
    end

endmodule

// ===== hdl/brl_step.sv =====
module brl_step #(
    parameter int ROW_SHIFT = brl_pkg::ROW_SHIFT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          held_valid,
    input  brl_pkg::request_t             held_word,
    input  brl_pkg::line_setup_t          setup,
    input  logic [brl_pkg::ADDR_BITS-1:0] base,
    output logic                          take,
    output logic                          out_valid,
    input  logic                          out_stall,
    output brl_pkg::result_t              out_word
);
    import brl_pkg::*;

    logic                  drawing_reg;
    logic                  drawing_next;
    logic                  steep_reg;
    logic [C_BITS-1:0]     major_pos_reg;
    logic [C_BITS-1:0]     major_pos_next;
    logic [C_BITS-1:0]     major_end_reg;
    logic [C_BITS-1:0]     minor_pos_reg;
    logic [C_BITS-1:0]     minor_pos_next;
    logic                  minor_down_reg;
    logic [ERR_BITS-1:0]   err_reg;
    logic [ERR_BITS-1:0]   err_next;
    logic [C_BITS-1:0]     delta_major_reg;
    logic [C_BITS-1:0]     delta_minor_reg;
    logic [COLOR_BITS-1:0] colour_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_word_reg;
    result_t               pix;

    logic                  is_start;
    logic                  is_pixel;
    logic                  last;
    logic [ERR_BITS-1:0]   err_sum;
    logic                  minor_step;
    logic [X_BITS-1:0]     px;
    logic [Y_BITS-1:0]     py;

    // The held word moves on whenever the result slot is free or emptying.
    assign take      = held_valid && (!out_valid_reg || !out_stall);
    assign is_start  = take && (held_word.req_type == REQ_START);
    assign is_pixel  = take && (held_word.req_type == REQ_TICK) && drawing_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Current pixel and its byte address.
    assign last = major_pos_reg == major_end_reg;
    assign px   = steep_reg ? minor_pos_reg[X_BITS-1:0] : major_pos_reg[X_BITS-1:0];
    assign py   = steep_reg ? major_pos_reg[Y_BITS-1:0] : minor_pos_reg[Y_BITS-1:0];

    always_comb
    begin
        pix.pixel_x       = px;
        pix.pixel_y       = py;
        pix.pixel_color   = colour_reg;
        pix.pixel_address = base + (ADDR_BITS'(py) << ROW_SHIFT) + (ADDR_BITS'(px) << 1);
        pix.last_pixel    = last;
    end

    // Error update; the minor axis never steps when its distance is zero.
    assign err_sum    = err_reg + ERR_BITS'(delta_minor_reg);
    assign minor_step = !err_sum[ERR_BITS-1] && (delta_minor_reg != '0);

    always_comb
    begin
        drawing_next   = drawing_reg;
        major_pos_next = major_pos_reg;
        minor_pos_next = minor_pos_reg;
        err_next       = err_reg;
        if (is_start)
        begin
            drawing_next   = 1'b1;
            major_pos_next = setup.major_pos;
            minor_pos_next = setup.minor_pos;
            err_next       = setup.err_init;
        end
        else if (is_pixel)
        begin
            if (last)
            begin
                drawing_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + 1'b1;
                if (minor_step)
                begin
                    minor_pos_next = minor_down_reg ? (minor_pos_reg - 1'b1)
                                                    : (minor_pos_reg + 1'b1);
                    err_next       = err_sum - ERR_BITS'(delta_major_reg);
                end
                else
                begin
                    err_next = err_sum;
                end
            end
        end
    end

    // Result slot: filled by a pixel, emptied when the receiver takes it.
    always_comb
    begin
        if (is_pixel)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Line walker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drawing_reg     <= 1'b0;
            steep_reg       <= 1'b0;
            major_pos_reg   <= '0;
            major_end_reg   <= '0;
            minor_pos_reg   <= '0;
            minor_down_reg  <= 1'b0;
            err_reg         <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            colour_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            drawing_reg   <= drawing_next;
            major_pos_reg <= major_pos_next;
            minor_pos_reg <= minor_pos_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (is_start)
            begin
                steep_reg       <= setup.steep;
                major_end_reg   <= setup.major_end;
                minor_down_reg  <= setup.minor_down;
                delta_major_reg <= setup.delta_major;
                delta_minor_reg <= setup.delta_minor;
                colour_reg      <= held_word.color;
            end
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (is_pixel)
        begin
            out_word_reg <= pix;
        end
    end

endmodule

// ===== test/bresenham_line_rasterizer_core_tb.sv =====
module bresenham_line_rasterizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brl_pkg::*;

    // Tracks the line walker from the accepted request words and holds the pixel
    // words that the block still owes, oldest first.
    class pixel_tracker;
        bit [ADDR_BITS-1:0]  base;
        bit                  drawing;
        bit                  steep;
        bit                  minor_down;
        bit [C_BITS-1:0]     major_pos;
        bit [C_BITS-1:0]     major_end;
        bit [C_BITS-1:0]     minor_pos;
        bit [C_BITS-1:0]     d_major;
        bit [C_BITS-1:0]     d_minor;
        bit [COLOR_BITS-1:0] colour;
        int                  err;
        result_t             pixels_due[$];
        int                  errors;
        int                  pixels_seen;
        int                  lines_started;

        function void set_base(bit [ADDR_BITS-1:0] value);
            base = value;
        endfunction

        function bit [C_BITS-1:0] span_of(bit [C_BITS-1:0] a, bit [C_BITS-1:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        // Updates the walker for one accepted request word and queues the pixel
        // word that a tick produces while a line is in progress.
        function void note_request(request_t req);
            bit [C_BITS-1:0]    x0, y0, x1, y1, a0, b0, a1, b1, t;
            bit [ADDR_BITS-1:0] row, col;
            result_t            px;
            if (req.req_type == REQ_START)
            begin
                x0 = req.x_start;
                y0 = C_BITS'(req.y_start);
                x1 = req.x_end;
                y1 = C_BITS'(req.y_end);
                steep = span_of(y1, y0) > span_of(x1, x0);
                if (steep)
                begin
                    a0 = y0; b0 = x0; a1 = y1; b1 = x1;
                end
                else
                begin
                    a0 = x0; b0 = y0; a1 = x1; b1 = y1;
                end
                // Order the endpoints so that the major coordinate rises.
                if (a0 > a1)
                begin
                    t = a0; a0 = a1; a1 = t;
                    t = b0; b0 = b1; b1 = t;
                end
                major_pos  = a0;
                major_end  = a1;
                minor_pos  = b0;
                minor_down = !(b0 < b1);
                d_major    = a1 - a0;
                d_minor    = span_of(b1, b0);
                err        = 0 - int'(d_major >> 1);
                colour     = req.color;
                drawing    = 1'b1;
                lines_started++;
            end
            else if (drawing)
            begin
                px.pixel_x       = steep ? minor_pos[X_BITS-1:0] : major_pos[X_BITS-1:0];
                px.pixel_y       = steep ? major_pos[Y_BITS-1:0] : minor_pos[Y_BITS-1:0];
                px.pixel_color   = colour;
                row              = ADDR_BITS'(px.pixel_y) << ROW_SHIFT_DEF;
                col              = ADDR_BITS'(px.pixel_x) << 1;
                px.pixel_address = base + row + col;
                px.last_pixel    = (major_pos == major_end);
                pixels_due.push_back(px);
                if (px.last_pixel)
                begin
                    drawing = 1'b0;
                end
                else
                begin
                    // A flat minor axis never steps, even when the error test passes.
                    err = err + int'(d_minor);
                    if (err >= 0 && d_minor != 0)
                    begin
                        minor_pos = minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
                        err       = err - int'(d_major);
                    end
                    major_pos = major_pos + 1'b1;
                end
            end
        endfunction

        task report(string msg);
            if (errors < 100)
            begin
                $display("[%0t] check failed: %s", $time, msg);
            end
            errors++;
        endtask

        // Compares one accepted pixel word with the oldest one owed.
        task check_pixel(result_t got);
            result_t want;
            if (pixels_due.size() == 0)
            begin
                report($sformatf("pixel word x=%0d y=%0d with no tick waiting",
                                 got.pixel_x, got.pixel_y));
                return;
            end
            want = pixels_due.pop_front();
            pixels_seen++;
            if (got.pixel_x !== want.pixel_x)
                report($sformatf("pixel %0d x: got %0d, expected %0d",
                                 pixels_seen, got.pixel_x, want.pixel_x));
            if (got.pixel_y !== want.pixel_y)
                report($sformatf("pixel %0d y: got %0d, expected %0d",
                                 pixels_seen, got.pixel_y, want.pixel_y));
            if (got.pixel_color !== want.pixel_color)
                report($sformatf("pixel %0d color: got %h, expected %h",
                                 pixels_seen, got.pixel_color, want.pixel_color));
            if (got.pixel_address !== want.pixel_address)
                report($sformatf("pixel %0d address: got %h, expected %h",
                                 pixels_seen, got.pixel_address, want.pixel_address));
            if (got.last_pixel !== want.last_pixel)
                report($sformatf("pixel %0d last flag: got %b, expected %b",
                                 pixels_seen, got.last_pixel, want.last_pixel));
        endtask

        task check_drained();
            if (pixels_due.size() != 0)
                report($sformatf("%0d pixel words never arrived", pixels_due.size()));
        endtask
    endclass

    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 4;
    localparam int PHASE_ITEMS = 190;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    request_t             in_word;
    logic                 out_valid;
    logic                 out_stall;
    result_t              out_word;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [ADDR_BITS-1:0] cfg_data;

    pixel_tracker tracker;
    bit           idle_on     = 1'b1;
    bit           sender_gaps = 1'b1;
    bit           hold_output = 1'b0;
    int           items_sent;
    int           base_writes;
    int           quiet_cycles;

    bresenham_line_rasterizer_core #(
        .ROW_SHIFT(ROW_SHIFT_DEF)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word (out_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every word that moves on either channel goes to the tracker.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_request(in_word);
            if (out_valid && !out_stall)
                tracker.check_pixel(out_word);
        end
    end

    // Receiver: random stall bursts, or one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_output = 1'b0;
                out_stall   = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Watchdog: the run ends if no word moves on any channel for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no word moved for %0d cycles.", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    function automatic request_t random_request();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(request_t)-1:0];
    endfunction

    function automatic request_t make_tick();
        request_t req;
        req          = random_request();
        req.req_type = REQ_TICK;
        return req;
    endfunction

    function automatic request_t make_start(int x0, int y0, int x1, int y1, int c);
        request_t req;
        req.req_type = REQ_START;
        req.x_start  = X_BITS'(x0);
        req.y_start  = Y_BITS'(y0);
        req.x_end    = X_BITS'(x1);
        req.y_end    = Y_BITS'(y1);
        req.color    = COLOR_BITS'(c);
        return req;
    endfunction

    function automatic int clamp(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    // Offers one request word, with an optional gap before it, and returns
    // once it has been accepted. Valid stays high afterwards.
    task automatic send(request_t req);
        if (sender_gaps && idle_on && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        else
        begin
            @(negedge clk);
        end
        in_word  = req;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        items_sent++;
    endtask

    // Stops offering and waits until every owed pixel word has arrived.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pixels_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes the buffer base while the block is idle, with no line open.
    task automatic write_base(logic [ADDR_BITS-1:0] value);
        drain();
        if (tracker.drawing)
        begin
            send(make_start(0, 0, 0, 0, 0));
            send(make_tick());
            drain();
        end
        @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        tracker.set_base(value);
        base_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One line with random endpoints, mostly short, followed by ticks that
    // finish it, overrun it into idle, or abandon it part way.
    task automatic draw_random_line();
        int x0, y0, x1, y1, d, kind, len, ticks;
        x0   = $urandom_range(0, 511);
        y0   = $urandom_range(0, 255);
        kind = $urandom_range(0, 9);
        if (kind < 8)
        begin
            x1 = clamp(x0 + $urandom_range(0, 30) - 15, 511);
            y1 = clamp(y0 + $urandom_range(0, 30) - 15, 255);
        end
        else if (kind == 8)
        begin
            x1 = $urandom_range(0, 511);
            y1 = $urandom_range(0, 255);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       begin x1 = $urandom_range(0, 511); y1 = y0; end
                1:       begin x1 = x0; y1 = $urandom_range(0, 255); end
                2:       begin x1 = x0; y1 = y0; end
                default:
                begin
                    d  = $urandom_range(0, 40);
                    d  = (d > 511 - x0) ? 511 - x0 : d;
                    d  = (d > 255 - y0) ? 255 - y0 : d;
                    x1 = x0 + d;
                    y1 = y0 + d;
                end
            endcase
        end
        send(make_start(x0, y0, x1, y1, $urandom_range(0, 65535)));
        len = (((x1 > x0) ? x1 - x0 : x0 - x1) > ((y1 > y0) ? y1 - y0 : y0 - y1)) ?
              ((x1 > x0) ? x1 - x0 : x0 - x1) : ((y1 > y0) ? y1 - y0 : y0 - y1);
        len = len + 1;
        case ($urandom_range(0, 19))
            0, 1, 2: ticks = $urandom_range(0, len - 1);
            3, 4:    ticks = len;
            default: ticks = len + $urandom_range(0, 2);
        endcase
        repeat (ticks) send(make_tick());
    endtask

    task automatic run_phase(int phase);
        int phase_end;
        phase_end = items_sent + PHASE_ITEMS;
        while (items_sent < phase_end)
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4)) send(random_request());
            else
                draw_random_line();
            // Long receiver hold-off while the sender keeps ticking.
            if (phase == 1 && items_sent > phase_end - PHASE_ITEMS / 2)
            begin
                hold_output = 1'b1;
                sender_gaps = 1'b0;
                send(make_start(0, 0, 200, 60, $urandom_range(0, 65535)));
                repeat (80) send(make_tick());
                sender_gaps = 1'b1;
                phase_end   = phase_end - 1;
                phase       = -1;
            end
            // Sender pauses until every owed word has come back.
            if (phase == 3 && items_sent > phase_end - PHASE_ITEMS / 2)
            begin
                drain();
                phase = -1;
            end
        end
    endtask

    initial
    begin
        logic [ADDR_BITS-1:0] bases [6];
        tracker  = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: corners, restarts, flat and single-point lines.
        write_base(32'h0000_0000);
        send(make_tick());                          // tick with no line open
        send(make_start(0, 0, 0, 0, 16'hFFFF));     // single point
        send(make_tick());
        send(make_tick());
        send(make_start(511, 255, 0, 0, 16'h0000)); // reversed, shallow
        repeat (3) send(make_tick());
        send(make_start(0, 255, 3, 0, 16'hA5A5));   // steep, minor going down
        repeat (4) send(make_tick());
        send(make_start(510, 20, 511, 20, 16'h5A5A)); // flat, one step long
        repeat (2) send(make_tick());
        send(make_start(5, 252, 5, 255, 16'h1234)); // vertical
        repeat (4) send(make_tick());
        send(make_tick());

        // Random phases, each under its own buffer base.
        bases[0] = 32'hFFFF_FFFF;
        bases[1] = $urandom;
        bases[2] = 32'h8000_0000;
        bases[3] = 32'hFFFF_F000;
        bases[4] = $urandom;
        bases[5] = 32'h0000_0000;
        for (int p = 0; p < 6; p++)
        begin
            write_base(bases[p]);
            if (p == 5)
                idle_on = 1'b0;
            run_phase(p);
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        tracker.check_drained();
        $display("Covered %0d line starts and %0d pixel words under %0d base settings,",
                 tracker.lines_started, tracker.pixels_seen, base_writes);
        $display("with restarts, idle ticks, address wrap and a long output hold-off.");
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/brl_pkg.sv
hdl/brl_in_stage.sv
hdl/brl_setup.sv
hdl/brl_step.sv
hdl/bresenham_line_rasterizer_core.sv
test/bresenham_line_rasterizer_core_tb.sv
